FILE: hw/rtl/modular_inverse_defines.svh
// assertion macros for the modular inverse block
// used by the top level only
`ifndef MODULAR_INVERSE_DEFINES_SVH
`define MODULAR_INVERSE_DEFINES_SVH

// assert that a condition implies another one in the same cycle
`define MI_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// assert that a condition implies another one in the next cycle
`define MI_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/minv_pkg.sv
// shared types and constants for the modular inverse block
// no dependencies
package minv_pkg;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned CNT_BITS  = $clog2(WORD_BITS + 1);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  typedef struct packed {
    word_t value;
    word_t modulus;
  } in_word_t;

  typedef struct packed {
    logic [31:0] inverse_out;
    logic        no_inverse;
  } out_word_t;
endpackage

FILE: hw/rtl/minv_if.sv
// valid/ready channel carrying one payload word
// no dependencies
interface minv_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/minv_div.sv
// restoring bit-serial divider, one quotient bit per cycle
// depends on minv_pkg
module minv_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  minv_pkg::word_t dividend,
  input  minv_pkg::word_t divisor,
  output logic          done,
  output minv_pkg::word_t quotient,
  output minv_pkg::word_t remainder
);
  import minv_pkg::*;

  logic          busy_r, busy_nxt;
  cnt_t          cnt_r, cnt_nxt;
  word_t         q_r, q_nxt;
  word_t         rem_r, rem_nxt;
  word_t         d_r, d_nxt;
  logic [WORD_BITS:0] trial;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_r, q_r[WORD_BITS-1]} - {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = cnt_t'(WORD_BITS);
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      if (trial[WORD_BITS]) begin
        rem_nxt = {rem_r[WORD_BITS-2:0], q_r[WORD_BITS-1]};
        q_nxt   = {q_r[WORD_BITS-2:0], 1'b0};
      end else begin
        rem_nxt = trial[WORD_BITS-1:0];
        q_nxt   = {q_r[WORD_BITS-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - cnt_t'(1);
      if (cnt_r == cnt_t'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // rem_r never exceeds the divisor, so the top shifted bit is safe to drop
  // only when the divisor fits; the trial uses the full width above

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  logic fin_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r <= 1'b0;
    end else begin
      fin_r <= busy_r && (cnt_r == cnt_t'(1));
    end
  end

  assign quotient  = q_r;
  assign remainder = rem_r;
  always_comb begin
    done = fin_r;
  end
endmodule

FILE: hw/rtl/modular_inverse.sv
// modular inverse by the extended euclidean algorithm, digit serial
// each euclid step: loop test, divide, then a shift-add multiply q*ub
// that stops once q runs out of bits; up to ~47 steps plus a final reduction divide
// throughput: one word in flight; a new word is taken once the result is read
// reset: synchronous active-low rst_n returns the sequencer to idle
`include "modular_inverse_defines.svh"
module modular_inverse (
  input logic clk,
  input logic rst_n,
  minv_if.sink   in_ch,
  minv_if.source out_ch
);
  import minv_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DIV  = 7'b0000010,
    ST_WDIV = 7'b0000100,
    ST_MUL  = 7'b0001000,
    ST_RED  = 7'b0010000,
    ST_WRED = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // remainder and coefficient chains
  word_t ra_r, ra_nxt, rb_r, rb_nxt;
  word_t ua_r, ua_nxt, ub_r, ub_nxt;
  word_t m_r, m_nxt;
  logic  odd_r, odd_nxt;
  // serial multiply-accumulate: un = ua + q*ub
  word_t mq_r, mq_nxt, macc_r, macc_nxt, mb_r, mb_nxt;
  cnt_t  mcnt_r, mcnt_nxt;
  word_t rn_r, rn_nxt;
  // result word and hold flag
  out_word_t res_r, res_nxt;
  logic      ov_r, ov_nxt;

  logic  div_start, div_done;
  word_t div_a, div_b, div_q, div_rem;

  minv_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q), .remainder(div_rem)
  );

  assign in_ch.ready = (state_r == ST_IDLE) && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.data  = res_r;

  word_t mag;
  always_comb begin
    state_nxt = state_r;
    ra_nxt = ra_r; rb_nxt = rb_r; ua_nxt = ua_r; ub_nxt = ub_r;
    m_nxt = m_r; odd_nxt = odd_r;
    mq_nxt = mq_r; macc_nxt = macc_r; mb_nxt = mb_r; mcnt_nxt = mcnt_r;
    rn_nxt = rn_r;
    res_nxt = res_r;
    ov_nxt = ov_r;
    div_start = 1'b0;
    div_a = ra_r;
    div_b = rb_r;
    mag = '0;
    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          m_nxt  = in_ch.data.modulus;
          ra_nxt = in_ch.data.modulus;
          rb_nxt = in_ch.data.value;
          ua_nxt = '0;
          ub_nxt = word_t'(1);
          odd_nxt = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // loop test: stop on remainder zero or one, or bad modulus
        if (m_r < word_t'(2) || rb_r == '0) begin
          res_nxt = '{inverse_out: 32'd0, no_inverse: 1'b1};
          state_nxt = ST_OUT;
        end else if (rb_r == word_t'(1)) begin
          div_a = ub_r;
          div_b = m_r;
          div_start = 1'b1;
          state_nxt = ST_WRED;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_WDIV;
        end
      end
      ST_WDIV: begin
        if (div_done) begin
          mq_nxt   = div_q;
          rn_nxt   = div_rem;
          mb_nxt   = ub_r;
          macc_nxt = ua_r;
          mcnt_nxt = cnt_t'(WORD_BITS);
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        // one multiplier bit per cycle, product bounded by the modulus
        if (mq_r[0]) begin
          macc_nxt = macc_r + mb_r;
        end
        mq_nxt = mq_r >> 1;
        mb_nxt = mb_r << 1;
        mcnt_nxt = mcnt_r - cnt_t'(1);
        if (mcnt_r == cnt_t'(1) || mq_r == '0) begin
          ra_nxt = rb_r; ua_nxt = ub_r;
          rb_nxt = rn_r;
          ub_nxt = mq_r[0] ? macc_r + mb_r : macc_r;
          odd_nxt = !odd_r;
          state_nxt = ST_DIV;
        end
      end
      ST_WRED: begin
        if (div_done) begin
          mag = div_rem;
          if (odd_r || mag == '0) begin
            res_nxt.inverse_out = 32'(mag);
          end else begin
            res_nxt.inverse_out = 32'(m_r - mag);
          end
          res_nxt.no_inverse = 1'b0;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ov_nxt) begin
          ov_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_RED: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    ra_r <= ra_nxt; rb_r <= rb_nxt; ua_r <= ua_nxt; ub_r <= ub_nxt;
    m_r <= m_nxt; odd_r <= odd_nxt;
    mq_r <= mq_nxt; macc_r <= macc_nxt; mb_r <= mb_nxt; mcnt_r <= mcnt_nxt;
    rn_r <= rn_nxt;
    res_r <= res_nxt;
  end

  // a no-inverse word always carries a zero inverse
  `MI_ASSERT_IMP(a_noinv_zero, clk, rst_n, ov_r && res_r.no_inverse, res_r.inverse_out == 32'd0)
  // a pending word that is not taken stays
  `MI_ASSERT_NEXT(a_hold, clk, rst_n, ov_r && !out_ch.ready, ov_r && $stable(res_r))
  // no new item while busy
  `MI_ASSERT_IMP(a_busy, clk, rst_n, in_ch.ready, state_r == ST_IDLE)
endmodule
